/* sv/assert_macros.svh */
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* sv/pwmsc_pkg.sv */
// Types and constants of the PWM submodule register file with input capture.
`default_nettype none

package pwmsc_pkg;

    localparam int WINDOW_BYTES = 512;
    localparam int SUBMODULES   = 4;
    localparam int ADDR_W       = $clog2(WINDOW_BYTES);
    localparam int LANES        = 4;
    localparam int LANE_W       = $clog2(LANES);
    localparam int ROW_W        = ADDR_W - LANE_W;
    localparam int BANK_ROWS    = WINDOW_BYTES / LANES;

    // Register byte offsets in the window
    localparam logic [ADDR_W-1:0] REG_INIT  = ADDR_W'(9'h002);
    localparam logic [ADDR_W-1:0] REG_CTRL  = ADDR_W'(9'h006);
    localparam logic [ADDR_W-1:0] REG_VAL0  = ADDR_W'(9'h00A);
    localparam logic [ADDR_W-1:0] REG_VAL1  = ADDR_W'(9'h00E);
    localparam logic [ADDR_W-1:0] REG_VAL5  = ADDR_W'(9'h01E);
    localparam logic [ADDR_W-1:0] REG_STS   = ADDR_W'(9'h024);
    localparam logic [ADDR_W-1:0] REG_INTEN = ADDR_W'(9'h026);
    localparam logic [ADDR_W-1:0] REG_DMAEN = ADDR_W'(9'h028);
    localparam logic [ADDR_W-1:0] REG_CAPTA = ADDR_W'(9'h034);
    localparam logic [ADDR_W-1:0] REG_CVAL0 = ADDR_W'(9'h040);
    localparam logic [ADDR_W-1:0] REG_MCTRL = ADDR_W'(9'h188);
    localparam logic [ADDR_W-1:0] REG_FSTS  = ADDR_W'(9'h18E);
    localparam int                SM_STEP   = 'h60;

    // Register bits
    localparam logic [15:0] STS_W1C   = 16'h7FFF;
    localparam logic [15:0] FSTS_W1C  = 16'h000F;
    localparam logic [15:0] BIT_RF    = 16'h1000;
    localparam logic [15:0] BIT_CFA0  = 16'h0400;
    localparam logic [15:0] BITS_CMPF = 16'h003F;
    localparam logic [15:0] IRQ_MASK  = BIT_RF | BIT_CFA0 | BITS_CMPF;
    localparam int          RUN_SM0_BIT  = 8;
    localparam int          VALDE_BIT    = 1;   // bit 9 of DMAEN, in its upper byte
    localparam int          CA0DE_BIT    = 4;   // bit 4 of DMAEN, in its lower byte
    localparam int          RUN_LSB      = 8;
    localparam int          RUN_W        = 4;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_READ    = 2'd1,
        CMD_WRITE   = 2'd2,
        CMD_CAPTURE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        EDGE_OFF  = 2'd0,
        EDGE_FALL = 2'd1,
        EDGE_RISE = 2'd2,
        EDGE_ANY  = 2'd3
    } t_edge_sel;

    typedef struct packed {
        t_cmd              cmd;
        logic [ADDR_W-1:0] address;
        logic [31:0]       write_data;
        logic [2:0]        access_size;
        logic              pin_level;
    } t_in_item;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq;
        logic        val_dma_request;
        logic        capture_dma_pulse;
    } t_out_item;

endpackage

`default_nettype wire

/* sv/pwm_submodule_with_capture.sv */
// PWM submodule register file with reload counter and input capture.
//
//  Channel | Dir | Handshake                  | Payload
//  --------+-----+----------------------------+-----------------------------
//  in      | in  | i_in_valid / o_in_stall    | i_in_item  (pwmsc_pkg::t_in_item)
//  out     | out | o_out_valid / i_out_stall  | o_out_item (pwmsc_pkg::t_out_item)
//
// One item per cycle sustained while out does not stall; the result passes through the item
// and bank read registers, then the result register.
// The window lives in four byte-lane banks, one read and one write per cycle each.
// After reset the banks are zeroed one row per cycle, all 128 rows, with in stalled.
// An out stall holds the result register; in stalls only during the clearing sweep or when
// the work stage holds an item that cannot move on.
`default_nettype none
`include "assert_macros.svh"

module pwm_submodule_with_capture (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  pwmsc_pkg::t_in_item   i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output pwmsc_pkg::t_out_item  o_out_item
);
    import pwmsc_pkg::*;

    // Handshake and pipeline
    logic                  in_accept;
    logic                  out_free;
    logic                  s1_adv;
    logic                  tick_adv;
    logic                  r_clearing;
    logic [ROW_W-1:0]      r_clr_row;
    logic                  r_s1_valid;
    t_in_item              r_s1_item;
    logic                  r_out_valid;
    t_out_item             r_out_item;
    t_out_item             res;

    // Bank access
    logic [LANES-1:0][ROW_W-1:0] rd_row;
    logic [LANES-1:0][ROW_W-1:0] cur_row;
    logic [LANES-1:0][7:0]       r_rd;
    logic [LANES-1:0]            r_fwd_we;
    logic [LANES-1:0][ROW_W-1:0] r_fwd_row;
    logic [LANES-1:0][7:0]       r_fwd_data;
    logic [LANES-1:0][7:0]       lane_byte;
    logic [LANES-1:0]            item_we;
    logic [LANES-1:0][ROW_W-1:0] item_row;
    logic [LANES-1:0][7:0]       item_data;
    logic [LANES-1:0]            mem_we;
    logic [LANES-1:0][ROW_W-1:0] mem_row;
    logic [LANES-1:0][7:0]       mem_data;

    // Item decode
    logic [ADDR_W-1:0]           a;
    logic [2:0]                  n_bytes;
    logic [LANES-1:0][ADDR_W:0]  ba;
    logic [LANES-1:0][7:0]       old_b;
    logic [31:0]                 rdata;
    logic                        mctrl_wr;
    logic                        sts_hit;
    logic                        sts_clr;
    logic                        fsts_clr;
    logic                        plain_wr;
    logic                        cap_rise;
    logic                        cap_fall;
    logic                        cap_match;
    t_edge_sel                   edge_sel;
    logic [15:0]                 cval;
    logic [ADDR_W-1:0]           wa;
    logic [2:0]                  wn;
    logic [LANES-1:0][7:0]       wb;
    logic [LANES-1:0][ADDR_W:0]  wba;
    logic [LANES-1:0]            wbe;

    // Counter and mirrored register state
    logic [15:0] r_cnt,   n_cnt;
    logic [6:0]  r_psc,   n_psc;
    logic        r_run,   n_run;
    logic        r_pin,   n_pin;
    logic        r_vdma,  n_vdma;
    logic [15:0] r_init,  n_init;
    logic [2:0]  r_prsc,  n_prsc;
    logic [15:0] r_val1,  n_val1;
    logic [15:0] r_sts,   n_sts;
    logic [15:0] r_inten, n_inten;
    logic        r_valde, n_valde;
    logic        r_ca0de, n_ca0de;
    logic [3:0]  r_capta, n_capta;
    logic        pulse;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign s1_adv      = r_s1_valid && out_free;
    assign tick_adv    = s1_adv && r_s1_item.cmd == CMD_TICK;
    assign o_in_stall  = r_clearing || (r_s1_valid && !out_free);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Rows each lane sees for an access: lanes below the start byte take the next row
    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            rd_row[j] = (LANE_W'(j) >= i_in_item.address[LANE_W-1:0])
                      ? i_in_item.address[ADDR_W-1:LANE_W]
                      : ROW_W'(i_in_item.address[ADDR_W-1:LANE_W] + 1'b1);
            cur_row[j] = (LANE_W'(j) >= r_s1_item.address[LANE_W-1:0])
                       ? r_s1_item.address[ADDR_W-1:LANE_W]
                       : ROW_W'(r_s1_item.address[ADDR_W-1:LANE_W] + 1'b1);
            // Take the byte written by the item just before if the bank read missed it
            lane_byte[j] = (r_fwd_we[j] && r_fwd_row[j] == cur_row[j])
                         ? r_fwd_data[j] : r_rd[j];
        end
    end

    for (genvar gj = 0; gj < LANES; gj++) begin : g_bank
        logic [7:0] r_mem [BANK_ROWS];

        always_ff @(posedge i_clk) begin
            if (mem_we[gj]) begin
                r_mem[mem_row[gj]] <= mem_data[gj];
            end
            if (in_accept) begin
                r_rd[gj] <= r_mem[rd_row[gj]];
            end
        end
    end

    // Decode the held item, read bytes and build the byte writes
    always_comb begin
        a        = r_s1_item.address;
        n_bytes  = (r_s1_item.access_size > 3'd4) ? 3'd4 : r_s1_item.access_size;
        rdata    = '0;
        for (int i = 0; i < LANES; i++) begin
            ba[i] = (ADDR_W+1)'({1'b0, a}) + (ADDR_W+1)'(i);
            if (ba[i][ADDR_W-1:0] == REG_STS) begin
                old_b[i] = r_sts[7:0];
            end else if (ba[i][ADDR_W-1:0] == ADDR_W'(REG_STS + 1'b1)) begin
                old_b[i] = r_sts[15:8];
            end else begin
                old_b[i] = lane_byte[ba[i][LANE_W-1:0]];
            end
            if (r_s1_item.cmd == CMD_READ && 3'(i) < n_bytes && !ba[i][ADDR_W]) begin
                rdata[8*i +: 8] = old_b[i];
            end
        end

        sts_hit = 1'b0;
        for (int k = 0; k < SUBMODULES; k++) begin
            if (a == ADDR_W'(k * SM_STEP) + REG_STS) begin
                sts_hit = 1'b1;
            end
        end
        mctrl_wr = r_s1_item.cmd == CMD_WRITE && n_bytes == 3'd2 && a == REG_MCTRL;
        sts_clr  = r_s1_item.cmd == CMD_WRITE && n_bytes == 3'd2 && sts_hit;
        fsts_clr = r_s1_item.cmd == CMD_WRITE && n_bytes == 3'd2 && a == REG_FSTS;
        plain_wr = r_s1_item.cmd == CMD_WRITE && n_bytes != 3'd0
                && !mctrl_wr && !sts_clr && !fsts_clr;

        edge_sel  = t_edge_sel'(r_capta[3:2]);
        cap_rise  = r_s1_item.pin_level && !r_pin;
        cap_fall  = !r_s1_item.pin_level && r_pin;
        cap_match = r_s1_item.cmd == CMD_CAPTURE && r_capta[0]
                 && ((edge_sel == EDGE_ANY && (cap_rise || cap_fall))
                  || (edge_sel == EDGE_RISE && cap_rise)
                  || (edge_sel == EDGE_FALL && cap_fall));
        cval      = r_run ? r_cnt : r_init;

        wa = a;
        wn = '0;
        for (int i = 0; i < LANES; i++) begin
            wb[i] = r_s1_item.write_data[8*i +: 8];
        end
        if (r_s1_item.cmd == CMD_WRITE) begin
            wn = n_bytes;
            if (mctrl_wr) begin
                wb[0] = '0;
                wb[1] = 8'({4'b0, r_s1_item.write_data[RUN_LSB +: RUN_W]});
            end else if (sts_clr) begin
                wb[0] = old_b[0] & ~(r_s1_item.write_data[7:0]  & STS_W1C[7:0]);
                wb[1] = old_b[1] & ~(r_s1_item.write_data[15:8] & STS_W1C[15:8]);
            end else if (fsts_clr) begin
                wb[0] = old_b[0] & ~(r_s1_item.write_data[7:0]  & FSTS_W1C[7:0]);
                wb[1] = old_b[1] & ~(r_s1_item.write_data[15:8] & FSTS_W1C[15:8]);
            end
        end else if (cap_match) begin
            wa    = REG_CVAL0;
            wn    = 3'd2;
            wb[0] = cval[7:0];
            wb[1] = cval[15:8];
        end

        for (int i = 0; i < LANES; i++) begin
            wba[i] = (ADDR_W+1)'({1'b0, wa}) + (ADDR_W+1)'(i);
            wbe[i] = s1_adv && 3'(i) < wn && !wba[i][ADDR_W];
        end
    end

    // Route the item's bytes to lanes; the clearing sweep takes all lanes
    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            item_we[j]   = wbe[LANE_W'(LANE_W'(j) - wa[LANE_W-1:0])];
            item_row[j]  = wba[LANE_W'(LANE_W'(j) - wa[LANE_W-1:0])][ADDR_W-1:LANE_W];
            item_data[j] = wb[LANE_W'(LANE_W'(j) - wa[LANE_W-1:0])];
            mem_we[j]    = r_clearing || item_we[j];
            mem_row[j]   = r_clearing ? r_clr_row : item_row[j];
            mem_data[j]  = r_clearing ? 8'h00 : item_data[j];
        end
    end

    // Next state of counter, flags and mirrored registers
    always_comb begin
        n_cnt   = r_cnt;
        n_psc   = r_psc;
        n_run   = r_run;
        n_pin   = r_pin;
        n_vdma  = r_vdma;
        n_init  = r_init;
        n_prsc  = r_prsc;
        n_val1  = r_val1;
        n_sts   = r_sts;
        n_inten = r_inten;
        n_valde = r_valde;
        n_ca0de = r_ca0de;
        n_capta = r_capta;
        pulse   = 1'b0;

        for (int i = 0; i < LANES; i++) begin
            if (wbe[i]) begin
                case (wba[i][ADDR_W-1:0])
                    REG_INIT:                       n_init[7:0]   = wb[i];
                    ADDR_W'(REG_INIT + 1'b1):       n_init[15:8]  = wb[i];
                    REG_CTRL:                       n_prsc        = wb[i][6:4];
                    REG_VAL1:                       n_val1[7:0]   = wb[i];
                    ADDR_W'(REG_VAL1 + 1'b1):       n_val1[15:8]  = wb[i];
                    REG_STS:                        n_sts[7:0]    = wb[i];
                    ADDR_W'(REG_STS + 1'b1):        n_sts[15:8]   = wb[i];
                    REG_INTEN:                      n_inten[7:0]  = wb[i];
                    ADDR_W'(REG_INTEN + 1'b1):      n_inten[15:8] = wb[i];
                    REG_DMAEN:                      n_ca0de       = wb[i][CA0DE_BIT];
                    ADDR_W'(REG_DMAEN + 1'b1):      n_valde       = wb[i][VALDE_BIT];
                    REG_CAPTA:                      n_capta       = wb[i][3:0];
                    default: ;
                endcase
            end
        end

        if (s1_adv) begin
            unique case (r_s1_item.cmd)
                CMD_TICK: begin
                    if (r_run) begin
                        if (8'({1'b0, r_psc}) + 8'd1 < (8'd1 << r_prsc)) begin
                            n_psc = 7'(r_psc + 1'b1);
                        end else begin
                            n_psc = '0;
                            if (r_cnt == r_val1) begin
                                // Reload: back to INIT, flag it, raise the value request if VALDE is set
                                n_cnt = r_init;
                                n_sts = n_sts | BIT_RF;
                                if (r_valde) begin
                                    n_vdma = 1'b1;
                                end
                            end else begin
                                n_cnt = 16'(r_cnt + 1'b1);
                            end
                        end
                    end
                end
                CMD_READ: ;
                CMD_WRITE: begin
                    if (mctrl_wr) begin
                        n_run = r_s1_item.write_data[RUN_SM0_BIT];
                        if (r_s1_item.write_data[RUN_SM0_BIT]) begin
                            n_cnt = r_init;
                            n_psc = '0;
                        end
                    end
                    // Drop the value request on a store that touches the VAL block
                    if (plain_wr
                        && (ADDR_W+1)'({1'b0, a}) + (ADDR_W+1)'(n_bytes)
                           > (ADDR_W+1)'(REG_VAL0)
                        && (ADDR_W+1)'({1'b0, a}) <= (ADDR_W+1)'(REG_VAL5) + 1'b1) begin
                        n_vdma = 1'b0;
                    end
                end
                CMD_CAPTURE: begin
                    n_pin = r_s1_item.pin_level;
                    if (cap_match) begin
                        n_sts = n_sts | BIT_CFA0;
                        pulse = r_ca0de;
                    end
                end
            endcase
        end

        res.read_data         = rdata;
        res.irq               = |(n_sts & n_inten & IRQ_MASK);
        res.val_dma_request   = n_vdma;
        res.capture_dma_pulse = pulse;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_row   <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fwd_we    <= '0;
            r_cnt       <= '0;
            r_psc       <= '0;
            r_run       <= 1'b0;
            r_pin       <= 1'b0;
            r_vdma      <= 1'b0;
            r_init      <= '0;
            r_prsc      <= '0;
            r_val1      <= '0;
            r_sts       <= '0;
            r_inten     <= '0;
            r_valde     <= 1'b0;
            r_ca0de     <= 1'b0;
            r_capta     <= '0;
        end else begin
            if (r_clearing) begin
                r_clr_row <= ROW_W'(r_clr_row + 1'b1);
                if (r_clr_row == ROW_W'(BANK_ROWS - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
            if (s1_adv) begin
                r_fwd_we <= item_we;
            end
            r_cnt   <= n_cnt;
            r_psc   <= n_psc;
            r_run   <= n_run;
            r_pin   <= n_pin;
            r_vdma  <= n_vdma;
            r_init  <= n_init;
            r_prsc  <= n_prsc;
            r_val1  <= n_val1;
            r_sts   <= n_sts;
            r_inten <= n_inten;
            r_valde <= n_valde;
            r_ca0de <= n_ca0de;
            r_capta <= n_capta;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_item <= i_in_item;
        end
        if (s1_adv) begin
            r_out_item <= res;
            r_fwd_row  <= item_row;
            r_fwd_data <= item_data;
        end
    end

    `ASSERT_IMPL(a_clear_empty, r_clearing, !r_s1_valid && !r_out_valid, "item during clear")
    `ASSERT_CLK(a_cnt_hold, !r_run |=> (r_run || $stable(r_cnt)), "counter moved while stopped")
    `ASSERT_IMPL(a_vdma_rise, $rose(r_vdma), $past(tick_adv), "value request rose off a tick")

endmodule

`default_nettype wire

/* tb/sv/pwm_submodule_with_capture_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the PWM submodule register file with reload counter and capture.
module pwm_submodule_with_capture_tb;
    import pwmsc_pkg::*;

    localparam int PERIOD     = 8;
    localparam int HALF_ITEMS = 550;
    localparam int HOLD_LEN   = 80;

    localparam logic [15:0] DMA_VALDE = 16'h0001 << (8 + VALDE_BIT);
    localparam logic [15:0] DMA_CA0DE = 16'h0001 << CA0DE_BIT;
    localparam logic [15:0] RUN_SM0   = 16'h0001 << RUN_SM0_BIT;
    localparam logic [15:0] RUN_BITS  = ((16'h0001 << RUN_W) - 16'h0001) << RUN_LSB;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    // Shadow copy of the block state
    logic [7:0]  win_bytes [WINDOW_BYTES];
    logic [15:0] ctr;
    logic [6:0]  psc;
    logic        ctr_run;
    logic        pin_prev;
    logic        valreq;

    t_in_item  stim_items [$];
    t_out_item predicted_outs [$];
    t_out_item want;
    int        errors = 0;
    int        sent_cnt = 0;
    int        got_cnt = 0;
    int        hold_left = 0;
    bit        hold_done = 1'b0;

    pwm_submodule_with_capture uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    always #(PERIOD / 2) clk = ~clk;

    function automatic logic [15:0] rd16(int a);
        logic [15:0] v;
        v = '0;
        if (a < WINDOW_BYTES) v[7:0] = win_bytes[a];
        if (a + 1 < WINDOW_BYTES) v[15:8] = win_bytes[a + 1];
        return v;
    endfunction

    function automatic void wr16(int a, logic [15:0] v);
        if (a < WINDOW_BYTES) win_bytes[a] = v[7:0];
        if (a + 1 < WINDOW_BYTES) win_bytes[a + 1] = v[15:8];
    endfunction

    function automatic void pwm_tick();
        int lim;
        if (!ctr_run) return;
        lim = 1 << ((rd16(REG_CTRL) >> 4) & 7);
        // a prescale count left above a lowered limit steps right away
        if (int'(psc) + 1 < lim) begin
            psc = psc + 7'd1;
            return;
        end
        psc = '0;
        if (ctr == rd16(REG_VAL1)) begin
            ctr = rd16(REG_INIT);
            wr16(REG_STS, rd16(REG_STS) | BIT_RF);
            if ((rd16(REG_DMAEN) & DMA_VALDE) != 0) valreq = 1'b1;
        end else begin
            ctr = ctr + 16'd1;
        end
    endfunction

    function automatic logic [31:0] pwm_read(int a, int n);
        logic [31:0] v;
        v = '0;
        for (int i = 0; i < n; i++) begin
            if (a + i < WINDOW_BYTES) v[8*i +: 8] = win_bytes[a + i];
        end
        return v;
    endfunction

    function automatic void pwm_write(int a, logic [31:0] d, int n);
        logic [15:0] run;
        if (n == 0) return;
        if (n == 2 && a == REG_MCTRL) begin
            run = d[15:0] & RUN_BITS;
            wr16(a, run);
            if ((run & RUN_SM0) != 0) begin
                ctr_run = 1'b1;
                ctr = rd16(REG_INIT);
                psc = '0;
            end else begin
                ctr_run = 1'b0;
            end
            return;
        end
        if (n == 2 && a < SM_STEP * SUBMODULES && a % SM_STEP == REG_STS) begin
            wr16(a, rd16(a) & ~(d[15:0] & STS_W1C));
            return;
        end
        if (n == 2 && a == REG_FSTS) begin
            wr16(a, rd16(a) & ~(d[15:0] & FSTS_W1C));
            return;
        end
        for (int i = 0; i < n; i++) begin
            if (a + i < WINDOW_BYTES) win_bytes[a + i] = d[8*i +: 8];
        end
        // any plain store into the VAL block drops the value request
        if (a + n > REG_VAL0 && a <= REG_VAL5 + 1) valreq = 1'b0;
    endfunction

    function automatic logic pwm_capture(logic lvl);
        logic [15:0] cap;
        t_edge_sel   mode;
        logic        rise;
        logic        fall;
        logic        hit;
        cap = rd16(REG_CAPTA);
        mode = t_edge_sel'(cap[3:2]);
        rise = lvl && !pin_prev;
        fall = !lvl && pin_prev;
        pin_prev = lvl;
        if (!cap[0]) return 1'b0;
        case (mode)
            EDGE_FALL: hit = fall;
            EDGE_RISE: hit = rise;
            EDGE_ANY:  hit = rise || fall;
            default:   hit = 1'b0;
        endcase
        if (!hit) return 1'b0;
        wr16(REG_CVAL0, ctr_run ? ctr : rd16(REG_INIT));
        wr16(REG_STS, rd16(REG_STS) | BIT_CFA0);
        return (rd16(REG_DMAEN) & DMA_CA0DE) != 0;
    endfunction

    function automatic t_out_item pwm_apply(t_in_item it);
        t_out_item o;
        int        n;
        o = '0;
        n = (it.access_size > 3'd4) ? 4 : int'(it.access_size);
        case (it.cmd)
            CMD_TICK:  pwm_tick();
            CMD_READ:  o.read_data = pwm_read(it.address, n);
            CMD_WRITE: pwm_write(it.address, it.write_data, n);
            default:   o.capture_dma_pulse = pwm_capture(it.pin_level);
        endcase
        o.irq = |(rd16(REG_STS) & rd16(REG_INTEN) & IRQ_MASK);
        o.val_dma_request = valreq;
        return o;
    endfunction

    function automatic t_in_item mk(t_cmd c, int a, logic [31:0] d, int n, logic p);
        t_in_item it;
        it.cmd = c;
        it.address = ADDR_W'(a);
        it.write_data = d;
        it.access_size = 3'(n);
        it.pin_level = p;
        return it;
    endfunction

    function automatic logic [ADDR_W-1:0] hot_addr();
        case ($urandom_range(0, 17))
            0:       return REG_INIT;
            1:       return REG_CTRL;
            2:       return REG_VAL0;
            3:       return REG_VAL1;
            4:       return REG_VAL1;
            5:       return REG_VAL5;
            6:       return REG_STS;
            7:       return REG_INTEN;
            8:       return REG_DMAEN;
            9:       return REG_CAPTA;
            10:      return REG_CAPTA;
            11:      return REG_CVAL0;
            12:      return REG_MCTRL;
            13:      return REG_FSTS;
            14:      return ADDR_W'(SM_STEP + REG_STS);
            15:      return ADDR_W'(3 * SM_STEP + REG_STS);
            16:      return ADDR_W'(WINDOW_BYTES - 2);
            default: return REG_MCTRL;
        endcase
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        int       r;
        it.cmd = CMD_TICK;
        it.address = ADDR_W'($urandom);
        it.write_data = $urandom;
        it.access_size = ($urandom_range(0, 9) < 7) ? 3'd2 : 3'($urandom_range(0, 7));
        it.pin_level = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 99);
        if (r < 38) begin
            it.cmd = CMD_TICK;
        end else if (r < 55) begin
            it.cmd = CMD_READ;
            if ($urandom_range(0, 3) != 0) it.address = hot_addr();
        end else if (r < 85) begin
            it.cmd = CMD_WRITE;
            if ($urandom_range(0, 4) != 0) it.address = hot_addr();
            // bias the control writes toward a running counter that reloads often
            if ($urandom_range(0, 3) != 0) begin
                case (it.address)
                    REG_INIT:  it.write_data[15:0] = 16'($urandom_range(0, 4));
                    REG_VAL1:  it.write_data[15:0] = 16'($urandom_range(3, 12));
                    REG_CTRL:  it.write_data[6:4] = 3'($urandom_range(0, 2));
                    REG_MCTRL: it.write_data[RUN_SM0_BIT] = 1'b1;
                    REG_CAPTA: it.write_data[0] = 1'b1;
                    default:   ;
                endcase
            end
        end else begin
            it.cmd = CMD_CAPTURE;
        end
        return it;
    endfunction

    function automatic void check_field(string f, logic [31:0] exp, logic [31:0] act);
        if (act !== exp) begin
            errors++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, f, exp, act);
        end
    endfunction

    task automatic wait_drained();
        while (stim_items.size() != 0 || in_valid || predicted_outs.size() != 0)
            @(negedge clk);
    endtask

    // Driver: predict on acceptance, then offer the next item or idle
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                predicted_outs.push_back(pwm_apply(in_item));
                sent_cnt++;
            end
            if (!in_valid || !in_stall) begin
                if (stim_items.size() != 0 &&
                    ((sent_cnt >= 500 && sent_cnt < 700) || hold_left != 0 ||
                     $urandom_range(0, 99) >= 27)) begin
                    in_item  <= stim_items.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each item against the oldest prediction
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (predicted_outs.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected item: expected none, actual %h", $time, out_item);
                end else begin
                    want = predicted_outs.pop_front();
                    check_field("read_data", want.read_data, out_item.read_data);
                    check_field("irq", 32'(want.irq), 32'(out_item.irq));
                    check_field("val_dma_request", 32'(want.val_dma_request),
                                32'(out_item.val_dma_request));
                    check_field("capture_dma_pulse", 32'(want.capture_dma_pulse),
                                32'(out_item.capture_dma_pulse));
                end
                got_cnt++;
            end
            // hold off once for long enough to back the block up into its input
            if (hold_left == 0 && !hold_done && got_cnt >= 300) begin
                hold_left = HOLD_LEN;
                hold_done = 1'b1;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= !(got_cnt >= 500 && got_cnt < 700) &&
                             ($urandom_range(0, 99) < 27);
            end
        end
    end

    initial begin
        for (int i = 0; i < WINDOW_BYTES; i++) win_bytes[i] = 8'h00;
        ctr = '0;
        psc = '0;
        ctr_run = 1'b0;
        pin_prev = 1'b0;
        valreq = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        stim_items.push_back(mk(CMD_READ, 0, 32'hFFFF_FFFF, 0, 1'b0));
        stim_items.push_back(mk(CMD_WRITE, REG_INIT, 32'h0000_FFFE, 2, 1'b0));
        stim_items.push_back(mk(CMD_WRITE, REG_VAL1, 32'h0000_0001, 2, 1'b0));
        stim_items.push_back(mk(CMD_WRITE, REG_DMAEN, 32'(DMA_VALDE | DMA_CA0DE), 2, 1'b0));
        stim_items.push_back(mk(CMD_WRITE, REG_INTEN, 32'(IRQ_MASK), 2, 1'b0));
        stim_items.push_back(mk(CMD_WRITE, REG_CAPTA, 32'({EDGE_ANY, 2'b01}), 2, 1'b0));
        // capture while stopped latches INIT; repeating the level is no edge
        stim_items.push_back(mk(CMD_CAPTURE, 0, 32'h0, 0, 1'b1));
        stim_items.push_back(mk(CMD_CAPTURE, 0, 32'h0, 0, 1'b1));
        stim_items.push_back(mk(CMD_WRITE, REG_MCTRL, 32'h0000_FFFF, 2, 1'b0));
        // start at INIT above VAL1: wrap through zero, then reload
        repeat (4) stim_items.push_back(mk(CMD_TICK, 0, 32'h0, 0, 1'b0));
        stim_items.push_back(mk(CMD_CAPTURE, 0, 32'h0, 0, 1'b0));
        stim_items.push_back(mk(CMD_READ, REG_STS, 32'h0, 7, 1'b0));
        stim_items.push_back(mk(CMD_WRITE, REG_STS, 32'hFFFF_FFFF, 2, 1'b0));
        stim_items.push_back(mk(CMD_WRITE, REG_VAL0, 32'h0000_00A5, 1, 1'b0));
        stim_items.push_back(mk(CMD_WRITE, REG_CTRL, 32'h0000_0070, 2, 1'b0));
        repeat (2) stim_items.push_back(mk(CMD_TICK, 0, 32'h0, 0, 1'b1));
        stim_items.push_back(mk(CMD_WRITE, REG_CTRL, 32'h0000_0000, 2, 1'b0));
        stim_items.push_back(mk(CMD_TICK, 0, 32'h0, 0, 1'b0));
        stim_items.push_back(mk(CMD_WRITE, REG_FSTS, 32'hFFFF_FFFF, 4, 1'b0));
        stim_items.push_back(mk(CMD_WRITE, REG_FSTS, 32'h0000_0005, 2, 1'b0));
        stim_items.push_back(mk(CMD_WRITE, WINDOW_BYTES - 2, 32'hA5A5_A5A5, 4, 1'b0));
        stim_items.push_back(mk(CMD_READ, WINDOW_BYTES - 3, 32'h0, 4, 1'b0));
        stim_items.push_back(mk(CMD_WRITE, SM_STEP + REG_STS, 32'h0000_0F0F, 2, 1'b0));
        stim_items.push_back(mk(CMD_WRITE, REG_MCTRL, 32'h0000_0000, 2, 1'b0));
        stim_items.push_back(mk(CMD_WRITE, REG_MCTRL, 32'h0000_0100, 4, 1'b0));
        stim_items.push_back(mk(CMD_TICK, 0, 32'h0, 0, 1'b0));
        // hold the sender until the block has answered everything
        wait_drained();

        for (int k = 0; k < HALF_ITEMS; k++) stim_items.push_back(rand_item());
        wait_drained();
        for (int k = 0; k < HALF_ITEMS; k++) stim_items.push_back(rand_item());
        wait_drained();
        repeat (12) @(negedge clk);

        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("simulation failed");
        $finish;
    end

endmodule
